/* hw/rtl/circle_segment_intersection_assert.svh */
// Assertion macros for the circle segment intersection top level.
`ifndef CIRCLE_SEGMENT_INTERSECTION_ASSERT_SVH
`define CIRCLE_SEGMENT_INTERSECTION_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CSI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/csi_pkg.sv */
// Shared types and constants of the circle segment intersection block.
package csi_pkg;

	typedef logic signed [31:0] coord_t;
	typedef logic [30:0]        radius_t;
	typedef logic [31:0]        cfg_data_t;
	typedef logic [1:0]         cfg_idx_t;

	localparam cfg_idx_t CFG_CENTER_X      = 2'd0;
	localparam cfg_idx_t CFG_CENTER_Y      = 2'd1;
	localparam cfg_idx_t CFG_CIRCLE_RADIUS = 2'd2;

	localparam int TOLERANCE_LSB = 64;

	// Integer square root: one result bit per stage.
	localparam int SQRT_ITERS   = 31;
	localparam int SQRT_W       = 62;
	localparam int SQRT_TOP_BIT = 2 * (SQRT_ITERS - 1);
	localparam int SQRT_FIRST   = 4;
	localparam int STAGES       = SQRT_FIRST + SQRT_ITERS;

	// Wide products b*b and a*c are cut into limbs.
	localparam int LIMB_W = 23;
	localparam int LIMBS  = 3;
	localparam int MAG_W  = LIMB_W * LIMBS;
	localparam int PP_W   = 2 * LIMB_W;
	localparam int ROW_W  = PP_W + 2 * LIMB_W + 1;
	localparam int PROD_W = 2 * MAG_W + 2;
	localparam int PROD_STAGE = 8;

endpackage

/* hw/rtl/csi_if.sv */
// Stream interfaces: segment beats in, hit beats out.
interface csi_seg_if;
	import csi_pkg::*;
	logic   valid;
	logic   ready;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface csi_hit_if;
	logic valid;
	logic ready;
	logic hit;
	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

/* hw/rtl/circle_segment_intersection.sv */
// Top level: pipelined circle boundary / line segment hit test.
//
// Usage: write center_x (index 0), center_y (index 1) and circle_radius
// (index 2) through cfg_we/cfg_index/cfg_data while no beat is in flight.
// Each beat on "segment" carries the two endpoints in signed Q16.16; each
// beat on "result" carries one hit bit, in input order.
// Throughput: one beat per cycle while the result does not stall.
// Depth: 35 register stages, set by the bit-per-stage square root of the
// axis case (31 stages), behind three stages of selection, multiply and sum
// and ahead of one output stage; the general case runs in parallel through
// limb products and an exact compare.
// Every stage has its own valid bit; a stage advances when the next one is
// empty or advancing, so bubbles are squeezed out and input is taken while
// the result stalls, until the pipeline is full.
// Reset clears all valid bits and the configuration registers to zero;
// no beat is lost or repeated across a stall of the receiver.
`include "circle_segment_intersection_assert.svh"

module circle_segment_intersection (
	input  logic                clk,
	input  logic                arst_n,
	csi_seg_if.sink             segment,
	csi_hit_if.source           result,
	input  logic                cfg_we,
	input  csi_pkg::cfg_idx_t   cfg_index,
	input  csi_pkg::cfg_data_t  cfg_data
);
	import csi_pkg::*;

	typedef struct packed {
		logic   is_gen;
		logic   cond;
		coord_t co;
		coord_t lo;
		coord_t hi;
		logic   gen_hit;
	} side_t;

	typedef struct packed {
		logic c_neg;
		logic c_zero;
		logic f_neg;
		logic f_zero;
		logic b_pos;
		logic ab_neg;
	} gen_flags_t;

	localparam logic signed [32:0] TOL = 33'(TOLERANCE_LSB);

	coord_t  center_x_q, center_y_q;
	radius_t circle_radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q      <= '0;
			center_y_q      <= '0;
			circle_radius_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTER_X:      center_x_q      <= cfg_data;
				CFG_CENTER_Y:      center_y_q      <= cfg_data;
				CFG_CIRCLE_RADIUS: circle_radius_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Valid bits and per-stage advance.
	logic vld_sn [1:STAGES];
	logic en [1:STAGES];

	always_comb begin
		en[STAGES] = !vld_sn[STAGES] || result.ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			en[k] = !vld_sn[k] || en[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= STAGES; k++) vld_sn[k] <= 1'b0;
		end else begin
			if (en[1]) vld_sn[1] <= segment.valid;
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) vld_sn[k] <= vld_sn[k - 1];
			end
		end
	end

	assign segment.ready = en[1];

	// Stage 1: differences and classification.
	logic signed [32:0] ddx_c, ddy_c, px_c, py_c;
	coord_t sx_s1, sy_s1, ex_s1, ey_s1;
	logic signed [32:0] dx_s1, dy_s1, px_s1, py_s1;
	logic vert_s1, horiz_s1;

	always_comb begin
		ddx_c = {segment.end_x[31], segment.end_x} - {segment.start_x[31], segment.start_x};
		ddy_c = {segment.end_y[31], segment.end_y} - {segment.start_y[31], segment.start_y};
		px_c  = {segment.start_x[31], segment.start_x} - {center_x_q[31], center_x_q};
		py_c  = {segment.start_y[31], segment.start_y} - {center_y_q[31], center_y_q};
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sx_s1    <= segment.start_x;
			sy_s1    <= segment.start_y;
			ex_s1    <= segment.end_x;
			ey_s1    <= segment.end_y;
			dx_s1    <= ddx_c;
			dy_s1    <= ddy_c;
			px_s1    <= px_c;
			py_s1    <= py_c;
			vert_s1  <= (ddx_c < TOL && ddx_c > -TOL) || ddx_c == '0;
			horiz_s1 <= ddy_c < TOL && ddy_c > -TOL;
		end
	end

	// Stage 2: products and axis-case selection.
	side_t side_sn [2:STAGES-1];
	logic signed [65:0] dxdx_s2, dydy_s2, dxpx_s2, dypy_s2, pxpx_s2, pypy_s2;
	logic [61:0] rr_s2;
	logic vert_s2;
	logic signed [32:0] d_c;
	logic [32:0] ad_c;
	side_t side_c;

	always_comb begin
		d_c  = vert_s1 ? px_s1 : py_s1;
		ad_c = d_c[32] ? 33'(-d_c) : 33'(d_c);
		side_c.is_gen  = !vert_s1 && !horiz_s1;
		side_c.cond    = {1'b0, ad_c} <= 34'(circle_radius_q) + 34'(TOLERANCE_LSB);
		side_c.co      = vert_s1 ? center_y_q : center_x_q;
		side_c.gen_hit = 1'b0;
		if (vert_s1) begin
			side_c.lo = (sy_s1 < ey_s1) ? sy_s1 : ey_s1;
			side_c.hi = (sy_s1 < ey_s1) ? ey_s1 : sy_s1;
		end else begin
			side_c.lo = (sx_s1 < ex_s1) ? sx_s1 : ex_s1;
			side_c.hi = (sx_s1 < ex_s1) ? ex_s1 : sx_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dxdx_s2    <= dx_s1 * dx_s1;
			dydy_s2    <= dy_s1 * dy_s1;
			dxpx_s2    <= dx_s1 * px_s1;
			dypy_s2    <= dy_s1 * py_s1;
			pxpx_s2    <= px_s1 * px_s1;
			pypy_s2    <= py_s1 * py_s1;
			rr_s2      <= circle_radius_q * circle_radius_q;
			vert_s2    <= vert_s1;
			side_sn[2] <= side_c;
		end
	end

	// Stage 3: quadratic coefficients and clamped root argument.
	logic signed [71:0] a_s3, b_s3, c_s3;
	logic [SQRT_W-1:0] rem_sn  [SQRT_FIRST-1:STAGES-1];
	logic [SQRT_W-1:0] root_sn [SQRT_FIRST-1:STAGES-1];
	logic [63:0] dd_c;

	assign dd_c = vert_s2 ? pxpx_s2[63:0] : pypy_s2[63:0];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			a_s3 <= 72'(dxdx_s2) + 72'(dydy_s2);
			b_s3 <= 72'(dxpx_s2) + 72'(dypy_s2);
			c_s3 <= 72'(pxpx_s2) + 72'(pypy_s2) - 72'(rr_s2);
			rem_sn[SQRT_FIRST-1]  <= ({2'b0, rr_s2} > dd_c) ? rr_s2 - dd_c[61:0] : '0;
			root_sn[SQRT_FIRST-1] <= '0;
		end
	end

	// Stage 4: end value, signs and magnitudes.
	logic signed [71:0] f1_c, ab_c;
	logic [71:0] bmag_c;
	logic [MAG_W-1:0] amag_s4, bmag_s4, cmag_s4;
	gen_flags_t flags_s4, flags_s5, flags_s6, flags_s7;

	always_comb begin
		f1_c   = a_s3 + (b_s3 <<< 1) + c_s3;
		ab_c   = a_s3 + b_s3;
		bmag_c = b_s3[71] ? 72'(-b_s3) : 72'(b_s3);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			amag_s4         <= a_s3[MAG_W-1:0];
			bmag_s4         <= bmag_c[MAG_W-1:0];
			cmag_s4         <= c_s3[MAG_W-1:0];
			flags_s4.c_neg  <= c_s3[71];
			flags_s4.c_zero <= c_s3 == '0;
			flags_s4.f_neg  <= f1_c[71];
			flags_s4.f_zero <= f1_c == '0;
			flags_s4.b_pos  <= !b_s3[71] && b_s3 != '0;
			flags_s4.ab_neg <= ab_c[71];
		end
	end

	// Stages 5 to 7: b*b and a*c from limb products.
	logic [PP_W-1:0] pp_bb_s5 [LIMBS][LIMBS];
	logic [PP_W-1:0] pp_ac_s5 [LIMBS][LIMBS];
	logic [ROW_W-1:0] row_bb_s6 [LIMBS];
	logic [ROW_W-1:0] row_ac_s6 [LIMBS];
	logic [PROD_W-1:0] bb_s7, ac_s7;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int i = 0; i < LIMBS; i++) begin
				for (int j = 0; j < LIMBS; j++) begin
					pp_bb_s5[i][j] <= bmag_s4[LIMB_W*i +: LIMB_W] * bmag_s4[LIMB_W*j +: LIMB_W];
					pp_ac_s5[i][j] <= amag_s4[LIMB_W*i +: LIMB_W] * cmag_s4[LIMB_W*j +: LIMB_W];
				end
			end
			flags_s5 <= flags_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int i = 0; i < LIMBS; i++) begin
				row_bb_s6[i] <= ROW_W'(pp_bb_s5[i][0]) + (ROW_W'(pp_bb_s5[i][1]) << LIMB_W)
					+ (ROW_W'(pp_bb_s5[i][2]) << (2 * LIMB_W));
				row_ac_s6[i] <= ROW_W'(pp_ac_s5[i][0]) + (ROW_W'(pp_ac_s5[i][1]) << LIMB_W)
					+ (ROW_W'(pp_ac_s5[i][2]) << (2 * LIMB_W));
			end
			flags_s6 <= flags_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			bb_s7 <= PROD_W'(row_bb_s6[0]) + (PROD_W'(row_bb_s6[1]) << LIMB_W)
				+ (PROD_W'(row_bb_s6[2]) << (2 * LIMB_W));
			ac_s7 <= PROD_W'(row_ac_s6[0]) + (PROD_W'(row_ac_s6[1]) << LIMB_W)
				+ (PROD_W'(row_ac_s6[2]) << (2 * LIMB_W));
			flags_s7 <= flags_s6;
		end
	end

	// General-case decision, folded into the side data at its stage.
	logic gen_hit_c;
	side_t side_fold_c;

	always_comb begin
		if ((flags_s7.c_neg || flags_s7.c_zero) && !flags_s7.f_neg) begin
			gen_hit_c = 1'b1;
		end else if (!flags_s7.c_neg && (flags_s7.f_neg || flags_s7.f_zero)) begin
			gen_hit_c = 1'b1;
		end else if (flags_s7.c_neg && flags_s7.f_neg) begin
			gen_hit_c = 1'b0;
		end else if (flags_s7.b_pos || flags_s7.ab_neg) begin
			gen_hit_c = 1'b0;
		end else begin
			gen_hit_c = bb_s7 >= ac_s7;
		end
	end

	always_comb begin
		side_fold_c         = side_sn[PROD_STAGE - 1];
		side_fold_c.gen_hit = gen_hit_c;
	end

	for (genvar k = 3; k <= STAGES - 1; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[k]) begin
				side_sn[k] <= (k == PROD_STAGE) ? side_fold_c : side_sn[k - 1];
			end
		end
	end

	// Integer square root, one result bit per stage.
	for (genvar i = 0; i < SQRT_ITERS; i++) begin : g_sqrt
		localparam int K = SQRT_FIRST + i;
		localparam logic [SQRT_W:0] BIT = (SQRT_W + 1)'(1) << (SQRT_TOP_BIT - 2 * i);
		logic [SQRT_W:0] trial;

		assign trial = {1'b0, root_sn[K - 1]} + BIT;

		if (K < STAGES) begin : g_reg
			always_ff @(posedge clk) begin
				if (en[K]) begin
					if ({1'b0, rem_sn[K - 1]} >= trial) begin
						rem_sn[K]  <= SQRT_W'({1'b0, rem_sn[K - 1]} - trial);
						root_sn[K] <= SQRT_W'({1'b0, root_sn[K - 1] >> 1} + BIT);
					end else begin
						rem_sn[K]  <= rem_sn[K - 1];
						root_sn[K] <= root_sn[K - 1] >> 1;
					end
				end
			end
		end
	end

	// Last stage: range test and output register.
	logic [SQRT_W-1:0] root_fin;
	logic signed [33:0] s_c, co_c, lo_c, hi_c, m_c, p_c;
	side_t side_l;
	logic hit_s35;

	assign side_l = side_sn[STAGES - 1];

	always_comb begin
		root_fin = root_sn[STAGES - 1];
		s_c  = {3'b0, root_fin[30:0]};
		co_c = {{2{side_l.co[31]}}, side_l.co};
		lo_c = {{2{side_l.lo[31]}}, side_l.lo};
		hi_c = {{2{side_l.hi[31]}}, side_l.hi};
		m_c  = co_c - s_c;
		p_c  = co_c + s_c;
	end

	always_ff @(posedge clk) begin
		if (en[STAGES]) begin
			hit_s35 <= side_l.is_gen ? side_l.gen_hit
				: side_l.cond && ((m_c >= lo_c && m_c <= hi_c) || (p_c >= lo_c && p_c <= hi_c));
		end
	end

	assign result.valid = vld_sn[STAGES];
	assign result.hit   = hit_s35;

	`CSI_ASSERT_NEXT(a_accept_fills, segment.valid && segment.ready, vld_sn[1], "accepted beat lost at stage 1")
	`CSI_ASSERT_IMP(a_root_bound, vld_sn[STAGES - 1], root_sn[STAGES - 1] <= {1'b0, 31'h7fffffff, 30'h0} >> 29, "square root out of range")
	`CSI_ASSERT_NEXT(a_stall_holds_full, vld_sn[STAGES] && !result.ready && vld_sn[STAGES - 1], vld_sn[STAGES - 1], "stalled stage dropped its beat")

endmodule
